FILE: rtl/qbv_pkg.sv
// Package for the shortest-arc quaternion block: word types, fixed-point constants,
// pipeline depths and the per-stage arithmetic steps shared by the modules.
// No dependencies.
package qbv_pkg;

  localparam int UNIT_BITS     = 30;
  localparam int OUT_FRAC_BITS = 30;
  localparam int OUT_SHIFT     = UNIT_BITS - OUT_FRAC_BITS;
  localparam logic [32:0] OUT_RND = 33'((2 ** OUT_SHIFT) >> 1);

  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = 31;
  localparam int XDIV_STEPS = 32;
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + UDIV_STEPS + 1;
  localparam int ALIGN      = UNIT_LAT - SQRT_STEPS - XDIV_STEPS;

  localparam logic signed [63:0] ONE_Q60   = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] OPP_LIMIT = -ONE_Q60 + 64'sd1152921504606847;
  localparam logic [63:0]        AXIS_MIN  = 64'd11529215046068470;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic signed [31:0] dest_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               opposite_case;
    logic               degenerate;
  } out_word_t;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][63:0] wide3_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
  } div_st_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] mul_s(logic [31:0] x, logic [31:0] y);
    logic signed [63:0] xe;
    logic signed [63:0] ye;
    xe = $signed(x);
    ye = $signed(y);
    return xe * ye;
  endfunction

  function automatic logic [63:0] sqrt_bit(int k);
    return 64'd1 << (2 * (SQRT_STEPS - 1 - k));
  endfunction

  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [63:0] b);
    logic [63:0] t;
    sqrt_st_t    r;
    t = st.root + b;
    if (st.rem >= t) begin
      r.rem  = st.rem - t;
      r.root = (st.root >> 1) + b;
    end else begin
      r.rem  = st.rem;
      r.root = st.root >> 1;
    end
    return r;
  endfunction

  function automatic div_st_t div_step(div_st_t st, logic [63:0] d);
    div_st_t r;
    if (st.rem >= d) begin
      r.rem = st.rem - d;
      r.quo = {st.quo[30:0], 1'b1};
    end else begin
      r.rem = st.rem;
      r.quo = {st.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] to_out(logic neg, logic [31:0] mag);
    logic [32:0] r;
    r = ({1'b0, mag} + OUT_RND) >> OUT_SHIFT;
    if (neg) begin
      if (r > 33'h0_8000_0000) begin
        r = 33'h0_8000_0000;
      end
      return ~r[31:0] + 32'd1;
    end
    if (r > 33'h0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return r[31:0];
  endfunction

endpackage

FILE: rtl/qbv_unit.sv
// Pipelined vector normalizer: scales a 3-vector given as sign and magnitude to unit
// length in Q2.30 through a bit-per-stage square root and divider.
// Depends on qbv_pkg.
module qbv_unit (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2:0]     neg_i,
  input  qbv_pkg::vec3_t mag_i,
  output logic           ok_o,
  output qbv_pkg::vec3_t u_o
);
  import qbv_pkg::*;

  function automatic logic [4:0] norm_shift(logic [31:0] top);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 30; i++) begin
      if (top[i]) begin
        k = 5'(30 - i);
      end
    end
    if (top[31:30] != 2'b00) begin
      k = '0;
    end
    return k;
  endfunction

  logic [31:0] top_d;
  logic [2:0]  neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  vec3_t       m1_q, m2_q, ms3_q, ms4_q, ms5_q;
  logic [31:0] top1_q;
  logic [4:0]  sh2_q;
  logic        ok2_q, ok3_q, ok4_q, ok5_q;
  wide3_t      sq4_q;
  logic [63:0] sum5_q;

  sqrt_st_t    rt_q [SQRT_STEPS];
  vec3_t       rm_q [SQRT_STEPS];
  logic [2:0]  rn_q [SQRT_STEPS];
  logic        rk_q [SQRT_STEPS];

  div_st_t     dv_q [UDIV_STEPS][3];
  logic [31:0] dl_q [UDIV_STEPS];
  logic [2:0]  dn_q [UDIV_STEPS];
  logic        dk_q [UDIV_STEPS];

  vec3_t       u_q;
  logic        ok_q;
  logic [31:0] len;

  always_comb begin
    top_d = mag_i[0];
    if (mag_i[1] > top_d) begin
      top_d = mag_i[1];
    end
    if (mag_i[2] > top_d) begin
      top_d = mag_i[2];
    end
  end

  assign len = rt_q[SQRT_STEPS-1].root[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_i;
      m1_q   <= mag_i;
      top1_q <= top_d;

      neg2_q <= neg1_q;
      m2_q   <= m1_q;
      sh2_q  <= norm_shift(top1_q);
      ok2_q  <= (top1_q != '0);

      neg3_q <= neg2_q;
      ok3_q  <= ok2_q;
      for (int i = 0; i < 3; i++) begin
        ms3_q[i] <= m2_q[i] << sh2_q;
      end

      neg4_q <= neg3_q;
      ok4_q  <= ok3_q;
      ms4_q  <= ms3_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 64'(ms3_q[i]) * 64'(ms3_q[i]);
      end

      neg5_q <= neg4_q;
      ok5_q  <= ok4_q;
      ms5_q  <= ms4_q;
      sum5_q <= sq4_q[0] + sq4_q[1] + sq4_q[2];

      rt_q[0] <= sqrt_step('{rem: sum5_q, root: 64'd0}, sqrt_bit(0));
      rm_q[0] <= ms5_q;
      rn_q[0] <= neg5_q;
      rk_q[0] <= ok5_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        rt_q[k] <= sqrt_step(rt_q[k-1], sqrt_bit(k));
        rm_q[k] <= rm_q[k-1];
        rn_q[k] <= rn_q[k-1];
        rk_q[k] <= rk_q[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        dv_q[0][i] <= div_step('{rem: 64'(rm_q[SQRT_STEPS-1][i]) << UNIT_BITS, quo: 32'd0},
                               64'(len) << (UDIV_STEPS - 1));
      end
      dl_q[0] <= len;
      dn_q[0] <= rn_q[SQRT_STEPS-1];
      dk_q[0] <= rk_q[SQRT_STEPS-1];
      for (int j = 1; j < UDIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_q[j][i] <= div_step(dv_q[j-1][i], 64'(dl_q[j-1]) << (UDIV_STEPS - 1 - j));
        end
        dl_q[j] <= dl_q[j-1];
        dn_q[j] <= dn_q[j-1];
        dk_q[j] <= dk_q[j-1];
      end

      for (int i = 0; i < 3; i++) begin
        u_q[i] <= dn_q[UDIV_STEPS-1][i] ? (~dv_q[UDIV_STEPS-1][i].quo + 32'd1)
                                        : dv_q[UDIV_STEPS-1][i].quo;
      end
      ok_q <= dk_q[UDIV_STEPS-1];
    end
  end

  assign u_o  = u_q;
  assign ok_o = ok_q;

endmodule

FILE: rtl/quaternion_between_vectors.sv
// Usage: shortest-arc rotation between two 3-vectors.
// The input channel (in_valid_i, in_stall_o, in_word_i) carries one word holding a
// start and a destination vector in signed Q16.16. The output channel (out_valid_o,
// out_stall_i, out_word_o) returns one word per input word, in order: the unit
// quaternion w, x, y, z in signed Q2.30 and the opposite_case and degenerate flags.
// A word is accepted at a rising edge where valid is high and stall is low.
// Throughput is one word per cycle while the receiver does not stall; the depth is set by two bit-per-stage square
// roots and two bit-per-stage dividers in series on the longest path.
// The whole pipeline advances together; when the output register holds a word and the
// receiver stalls, every stage holds and in_stall_o is raised in the same cycle.
// Reset clears all valid bits, so the block comes out of reset empty and ready.
// Depends on qbv_pkg and qbv_unit.
module quaternion_between_vectors (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qbv_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qbv_pkg::out_word_t  out_word_o
);
  import qbv_pkg::*;

  logic        en;
  vec3_t       sa_mag, sb_mag, a, b, ua_ax;
  logic [2:0]  sa_neg, sb_neg;
  logic        ok_a, ok_b, ok_ax;

  logic [UNIT_LAT-1:0] uv_q;
  logic        v1_q, v2_q, v3_q;
  logic        deg1_q, deg2_q, deg3_q;
  logic signed [63:0] pc1_q [3];
  logic signed [63:0] px1_q [6];
  logic signed [63:0] pa1_q [2];
  vec3_t       a1_q, a2_q;

  logic signed [63:0] cos2_q;
  logic [63:0] cr2_q [3];
  logic [63:0] asum2_q;

  vec3_t       ax;
  logic        opp3_q;
  logic [63:0] arg3_q;
  logic [2:0]  crn3_q, axn3_q;
  wide3_t      crm3_q;
  vec3_t       axm3_q;

  logic [SQRT_STEPS-1:0] nv_q;
  sqrt_st_t    nr_q [SQRT_STEPS];
  logic [2:0]  nn_q [SQRT_STEPS];
  wide3_t      nm_q [SQRT_STEPS];
  logic        no_q [SQRT_STEPS];
  logic        nd_q [SQRT_STEPS];

  logic [XDIV_STEPS-1:0] xv_q;
  div_st_t     xq_q [XDIV_STEPS][3];
  logic [31:0] xs_q [XDIV_STEPS];
  logic [2:0]  xn_q [XDIV_STEPS];
  logic        xo_q [XDIV_STEPS];
  logic        xd_q [XDIV_STEPS];
  logic [31:0] s_root;

  logic [ALIGN-1:0] lv_q;
  vec3_t       lq_q [ALIGN];
  logic [31:0] ls_q [ALIGN];
  logic [2:0]  ln_q [ALIGN];
  logic        lo_q [ALIGN];
  logic        ld_q [ALIGN];

  logic [3:0]        qn;
  logic [3:0][31:0]  qm;
  out_word_t         out_d;
  out_word_t         out_q;
  logic              out_vld_q;

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  always_comb begin
    sa_neg = {in_word_i.start_z[31], in_word_i.start_y[31], in_word_i.start_x[31]};
    sb_neg = {in_word_i.dest_z[31], in_word_i.dest_y[31], in_word_i.dest_x[31]};
    sa_mag[0] = mag32(in_word_i.start_x);
    sa_mag[1] = mag32(in_word_i.start_y);
    sa_mag[2] = mag32(in_word_i.start_z);
    sb_mag[0] = mag32(in_word_i.dest_x);
    sb_mag[1] = mag32(in_word_i.dest_y);
    sb_mag[2] = mag32(in_word_i.dest_z);
  end

  qbv_unit u_unit_a (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (sa_neg),
    .mag_i (sa_mag),
    .ok_o  (ok_a),
    .u_o   (a)
  );

  qbv_unit u_unit_b (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (sb_neg),
    .mag_i (sb_mag),
    .ok_o  (ok_b),
    .u_o   (b)
  );

  always_comb begin
    ax = '0;
    if (asum2_q < AXIS_MIN) begin
      ax[1] = ~a2_q[2] + 32'd1;
      ax[2] = a2_q[1];
    end else begin
      ax[0] = ~a2_q[1] + 32'd1;
      ax[1] = a2_q[0];
    end
  end

  qbv_unit u_unit_axis (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (axn3_q),
    .mag_i (axm3_q),
    .ok_o  (ok_ax),
    .u_o   (ua_ax)
  );

  assign s_root = nr_q[SQRT_STEPS-1].root[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_q      <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      nv_q      <= '0;
      xv_q      <= '0;
      lv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      uv_q      <= {uv_q[UNIT_LAT-2:0], in_valid_i};
      v1_q      <= uv_q[UNIT_LAT-1];
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      nv_q      <= {nv_q[SQRT_STEPS-2:0], v3_q};
      xv_q      <= {xv_q[XDIV_STEPS-2:0], nv_q[SQRT_STEPS-1]};
      lv_q      <= {lv_q[ALIGN-2:0], xv_q[XDIV_STEPS-1]};
      out_vld_q <= lv_q[ALIGN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc1_q[0] <= mul_s(a[0], b[0]);
      pc1_q[1] <= mul_s(a[1], b[1]);
      pc1_q[2] <= mul_s(a[2], b[2]);
      px1_q[0] <= mul_s(a[1], b[2]);
      px1_q[1] <= mul_s(a[2], b[1]);
      px1_q[2] <= mul_s(a[2], b[0]);
      px1_q[3] <= mul_s(a[0], b[2]);
      px1_q[4] <= mul_s(a[0], b[1]);
      px1_q[5] <= mul_s(a[1], b[0]);
      pa1_q[0] <= mul_s(a[0], a[0]);
      pa1_q[1] <= mul_s(a[1], a[1]);
      a1_q     <= a;
      deg1_q   <= !(ok_a && ok_b);

      cos2_q   <= pc1_q[0] + pc1_q[1] + pc1_q[2];
      cr2_q[0] <= px1_q[0] - px1_q[1];
      cr2_q[1] <= px1_q[2] - px1_q[3];
      cr2_q[2] <= px1_q[4] - px1_q[5];
      asum2_q  <= pa1_q[0] + pa1_q[1];
      a2_q     <= a1_q;
      deg2_q   <= deg1_q;

      opp3_q   <= cos2_q < OPP_LIMIT;
      arg3_q   <= (ONE_Q60 + cos2_q) << 1;
      deg3_q   <= deg2_q;
      for (int i = 0; i < 3; i++) begin
        crn3_q[i] <= cr2_q[i][63];
        crm3_q[i] <= mag64(cr2_q[i]);
        axn3_q[i] <= ax[i][31];
        axm3_q[i] <= mag32(ax[i]);
      end

      nr_q[0] <= sqrt_step('{rem: arg3_q, root: 64'd0}, sqrt_bit(0));
      nn_q[0] <= crn3_q;
      nm_q[0] <= crm3_q;
      no_q[0] <= opp3_q;
      nd_q[0] <= deg3_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        nr_q[k] <= sqrt_step(nr_q[k-1], sqrt_bit(k));
        nn_q[k] <= nn_q[k-1];
        nm_q[k] <= nm_q[k-1];
        no_q[k] <= no_q[k-1];
        nd_q[k] <= nd_q[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        xq_q[0][i] <= div_step('{rem: nm_q[SQRT_STEPS-1][i], quo: 32'd0},
                               64'(s_root) << (XDIV_STEPS - 1));
      end
      xs_q[0] <= s_root;
      xn_q[0] <= nn_q[SQRT_STEPS-1];
      xo_q[0] <= no_q[SQRT_STEPS-1];
      xd_q[0] <= nd_q[SQRT_STEPS-1];
      for (int j = 1; j < XDIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          xq_q[j][i] <= div_step(xq_q[j-1][i], 64'(xs_q[j-1]) << (XDIV_STEPS - 1 - j));
        end
        xs_q[j] <= xs_q[j-1];
        xn_q[j] <= xn_q[j-1];
        xo_q[j] <= xo_q[j-1];
        xd_q[j] <= xd_q[j-1];
      end

      for (int i = 0; i < 3; i++) begin
        lq_q[0][i] <= xq_q[XDIV_STEPS-1][i].quo;
      end
      ls_q[0] <= xs_q[XDIV_STEPS-1];
      ln_q[0] <= xn_q[XDIV_STEPS-1];
      lo_q[0] <= xo_q[XDIV_STEPS-1];
      ld_q[0] <= xd_q[XDIV_STEPS-1];
      for (int k = 1; k < ALIGN; k++) begin
        lq_q[k] <= lq_q[k-1];
        ls_q[k] <= ls_q[k-1];
        ln_q[k] <= ln_q[k-1];
        lo_q[k] <= lo_q[k-1];
        ld_q[k] <= ld_q[k-1];
      end

      out_q <= out_d;
    end
  end

  always_comb begin
    qn = '0;
    qm = '0;
    if (!ld_q[ALIGN-1]) begin
      if (lo_q[ALIGN-1]) begin
        if (ok_ax) begin
          for (int i = 0; i < 3; i++) begin
            qn[i+1] = ua_ax[i][31];
            qm[i+1] = mag32(ua_ax[i]);
          end
        end
      end else begin
        qm[0] = ls_q[ALIGN-1] >> 1;
        for (int i = 0; i < 3; i++) begin
          qn[i+1] = ln_q[ALIGN-1][i];
          qm[i+1] = lq_q[ALIGN-1][i];
        end
      end
    end
    out_d.quat_w        = to_out(qn[0], qm[0]);
    out_d.quat_x        = to_out(qn[1], qm[1]);
    out_d.quat_y        = to_out(qn[2], qm[2]);
    out_d.quat_z        = to_out(qn[3], qm[3]);
    out_d.opposite_case = lo_q[ALIGN-1] && !ld_q[ALIGN-1];
    out_d.degenerate    = ld_q[ALIGN-1];
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/qbv_check.sv
// Port-level checker for quaternion_between_vectors, attached by the bind below.
// Depends on qbv_pkg.
module qbv_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input qbv_pkg::in_word_t   in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input qbv_pkg::out_word_t  out_word_o
);
  import qbv_pkg::*;

  // A degenerate word carries an all-zero quaternion and never the opposite flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.degenerate |->
      out_word_o.quat_w == '0 && out_word_o.quat_x == '0 &&
      out_word_o.quat_y == '0 && out_word_o.quat_z == '0 && !out_word_o.opposite_case)
    else $error("degenerate word with nonzero payload");

  // A half turn has no scalar part.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.opposite_case |-> out_word_o.quat_w == '0)
    else $error("opposite word with nonzero w");

  // The input side is held back only while a finished word waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output register");

  // A stalled output word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

endmodule

bind quaternion_between_vectors qbv_check u_qbv_check (.*);
